[sv/crc32ws_pkg.sv]
// ----------------------------------------------------------------------------
// crc32ws_pkg
// Shared constants and the byte-wise CRC-32 update for the word stream block.
// ----------------------------------------------------------------------------
package crc32ws_pkg;

  localparam int unsigned DataWidth  = 64;
  localparam int unsigned CrcWidth   = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NumBytes   = DataWidth / ByteWidth;
  localparam int unsigned CountWidth = 4;

  localparam logic [CrcWidth-1:0]   CrcPoly  = 32'hEDB8_8320;
  localparam logic [ByteWidth-1:0]  ByteMask = 8'hff;
  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(NumBytes);

  typedef logic [CrcWidth-1:0]   crc_t;
  typedef logic [DataWidth-1:0]  data_t;
  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [CountWidth-1:0] count_t;

  // Fold one byte into a reflected CRC-32 remainder, one bit per step.
  function automatic crc_t crc_fold_byte(crc_t rem, byte_t data);
    crc_t r;
    r = rem ^ {{(CrcWidth-ByteWidth){1'b0}}, data & ByteMask};
    for (int k = 0; k < ByteWidth; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

[sv/crc32ws_fold.sv]
// ----------------------------------------------------------------------------
// crc32ws_fold
// Parallel CRC-32 update of one 64-bit word with a low-order byte enable.
// ----------------------------------------------------------------------------
module crc32ws_fold (
  input  crc32ws_pkg::crc_t   rem_in,
  input  crc32ws_pkg::data_t  data_word,
  input  crc32ws_pkg::count_t valid_bytes,
  output crc32ws_pkg::crc_t   rem_out
);
  import crc32ws_pkg::*;

  crc_t   chain [NumBytes+1];
  count_t byte_cnt;

  // Counts above a full word are treated as a full word.
  always_comb begin
    if (valid_bytes > MaxCount) begin
      byte_cnt = MaxCount;
    end else begin
      byte_cnt = valid_bytes;
    end
  end

  // One fixed XOR stage per byte lane; each tap is the remainder after b bytes.
  assign chain[0] = rem_in;

  for (genvar b = 0; b < NumBytes; b++) begin : g_lane
    assign chain[b+1] = crc_fold_byte(chain[b], data_word[b*ByteWidth +: ByteWidth]);
  end

  // Pick the tap that matches the byte count.
  assign rem_out = chain[byte_cnt];

endmodule

[sv/crc32ws_out_reg.sv]
// ----------------------------------------------------------------------------
// crc32ws_out_reg
// Result register that holds a finished CRC until the consumer takes it.
// ----------------------------------------------------------------------------
module crc32ws_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  crc32ws_pkg::crc_t load_crc,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_stall,
  output crc32ws_pkg::crc_t out_crc_value
);
  import crc32ws_pkg::*;

  logic valid_r;
  logic valid_nxt;
  crc_t crc_r;

  // The slot can take a new result if it is empty or is being drained now.
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload has no reset; it only changes on a load.
  always_ff @(posedge clk) begin
    if (load) begin
      crc_r <= load_crc;
    end
  end

  assign out_valid     = valid_r;
  assign out_crc_value = crc_r;

endmodule

[sv/crc32_word_stream_top.sv]
// ----------------------------------------------------------------------------
// crc32_word_stream_top
// Streaming reflected CRC-32 (polynomial 0xEDB88320) over 64-bit words.
// ----------------------------------------------------------------------------
// Each request carries eight little-endian message bytes, of which the low
// in_valid_bytes (0 to 8; larger counts act as 8) are folded into the running
// remainder with no inversion before or after. A request with in_first_word
// set starts from in_seed; one with in_last_word set yields the final
// remainder on the out_ channel. The block takes one word per clock unless the
// input is stalled: a word is held in the input register, the whole 64-bit XOR
// update runs combinationally from that register and writes the remainder
// register, and the remainder after a last word is loaded into the output
// register. The input stalls only while a last word waits for a stalled output
// register.
module crc32_word_stream_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crc32ws_pkg::data_t    in_data_word,
  input  crc32ws_pkg::count_t   in_valid_bytes,
  input  logic                  in_first_word,
  input  logic                  in_last_word,
  input  crc32ws_pkg::crc_t     in_seed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output crc32ws_pkg::crc_t     out_crc_value
);
  import crc32ws_pkg::*;

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  data_t  s1_data_r;
  count_t s1_count_r;
  logic   s1_first_r;
  logic   s1_last_r;
  crc_t   s1_seed_r;
  crc_t   rem_r;
  crc_t   rem_nxt;
  crc_t   rem_start;
  crc_t   rem_word;
  logic   s1_adv;
  logic   slot_free;
  logic   in_take;

  // The held word moves on unless it is a last word and the result slot is full.
  assign s1_adv   = s1_valid_r && (!s1_last_r || slot_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register valid bit.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_data_word;
      s1_count_r <= in_valid_bytes;
      s1_first_r <= in_first_word;
      s1_last_r  <= in_last_word;
      s1_seed_r  <= in_seed;
    end
  end

  // A first word restarts from its seed, others continue the stored remainder.
  assign rem_start = s1_first_r ? s1_seed_r : rem_r;

  crc32ws_fold u_fold (
    .rem_in      (rem_start),
    .data_word   (s1_data_r),
    .valid_bytes (s1_count_r),
    .rem_out     (rem_word)
  );

  // Running remainder.
  assign rem_nxt = s1_adv ? rem_word : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  crc32ws_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (s1_adv && s1_last_r),
    .load_crc      (rem_word),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

`ifndef ASSERT_OFF
  // The input only stalls while a word is held.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // A last word never advances into a full, stalled result register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s1_valid_r && s1_last_r) |-> in_stall)
    else $error("last word advanced over a pending result");

  // The remainder changes only when a word is processed.
  a_rem_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(rem_r))
    else $error("remainder changed without a processed word");

  // A result appears only after a last word was processed.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last word");
`endif

endmodule
